/* rtl/pce_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pce_pkg: shared types and constants of the path percent escaper
// Holds the queue entry layout, the match state codes, the special byte
// values and the helpers that classify a byte and turn a nibble into hex.
// ---------------------------------------------------------------------------
package pce_pkg;

	// Default number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Bytes of the modifier-letter colon, and the characters used in escapes.
	localparam logic [7:0] PFX_FIRST   = 8'hEA;
	localparam logic [7:0] PFX_SECOND  = 8'h9E;
	localparam logic [7:0] PFX_THIRD   = 8'h89;
	localparam logic [7:0] CHAR_PCT    = 8'h25;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CTRL_LOW    = 8'h01;
	localparam logic [7:0] CTRL_HIGH   = 8'h1F;
	localparam logic [3:0] DIGIT_LIMIT = 4'h9;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_A_BASE = 8'h37;

	// Progress through the three-byte colon sequence.
	typedef enum logic [1:0] {
		MATCH_IDLE = 2'd0,
		MATCH_EA   = 2'd1,
		MATCH_EA9E = 2'd2
	} match_t;

	// What the body of an entry produces after its flushed prefix bytes.
	typedef enum logic [1:0] {
		BODY_NONE = 2'd0,
		BODY_LIT  = 2'd1,
		BODY_ESC  = 2'd2
	} body_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic [1:0] pfx_n;
		body_t      kind;
		logic [7:0] body;
		logic       fin;
	} entry_t;

	// True for bytes that must go out as a percent escape.
	function automatic logic needs_escape(input logic [7:0] b);
		logic r;
		r = (b >= CTRL_LOW) && (b <= CTRL_HIGH);
		case (b)
			8'h22, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h3A, 8'h3B,
			8'h3D, 8'h3F, 8'h40, 8'h23, 8'h20, 8'h25: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	// Uppercase hex digit of a nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n > DIGIT_LIMIT) begin
			r = CHAR_A_BASE + {4'd0, n};
		end else begin
			r = CHAR_ZERO + {4'd0, n};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/path_percent_escaper.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// path_percent_escaper: percent escaping of a path string
// Escapes reserved and control bytes and the UTF-8 modifier-letter colon,
// holding prefix bytes until a match completes or breaks.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  input    src_valid/src_stall   in_byte[7:0], final_byte
//  output   dst_valid/dst_stall   out_byte[7:0], run_end, string_end
//
// The back end sends one byte per cycle unless the output stalls: a literal
// item is one byte, an escaped item three, a flushed prefix one or two more,
// an absorbed prefix byte none. The front takes an item every cycle while the
// queue has room. Reset clears the match state, the queue and output valid.
// A stall on the output fills the queue, and then the input is stalled.
// ---------------------------------------------------------------------------
module path_percent_escaper #(
	parameter int QDEPTH = pce_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       final_byte,
	output logic            dst_valid,
	input  wire logic       dst_stall,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            string_end
);

	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	pce_pkg::entry_t push_entry;
	pce_pkg::entry_t head;

	pce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	pce_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	pce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
`default_nettype wire

/* rtl/pce_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pce_front: input side of the escaper
// Accepts items, tracks the colon prefix match and turns each item into a
// queue entry describing the bytes it releases.
// ---------------------------------------------------------------------------
module pce_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            src_valid,
	output logic                 src_stall,
	input  wire logic [7:0]      in_byte,
	input  wire logic            final_byte,
	input  wire logic            q_full,
	output logic                 push,
	output pce_pkg::entry_t      push_entry
);

	pce_pkg::match_t match_q;
	pce_pkg::match_t match_d;
	logic            accept;
	logic            fresh_pend;
	pce_pkg::body_t  fresh_kind;
	logic            emits;

	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;

	// Treatment of the byte as if nothing were pending.
	always_comb begin
		fresh_pend = (in_byte == pce_pkg::PFX_FIRST) && !final_byte;
		if (fresh_pend) begin
			fresh_kind = pce_pkg::BODY_NONE;
		end else if (pce_pkg::needs_escape(in_byte)) begin
			fresh_kind = pce_pkg::BODY_ESC;
		end else begin
			fresh_kind = pce_pkg::BODY_LIT;
		end
	end

	// Next match state.
	always_comb begin
		match_d = pce_pkg::MATCH_IDLE;
		case (match_q)
			pce_pkg::MATCH_EA: begin
				if (in_byte == pce_pkg::PFX_SECOND && !final_byte) begin
					match_d = pce_pkg::MATCH_EA9E;
				end else if (fresh_pend) begin
					match_d = pce_pkg::MATCH_EA;
				end
			end
			pce_pkg::MATCH_EA9E: begin
				if (in_byte != pce_pkg::PFX_THIRD && fresh_pend) begin
					match_d = pce_pkg::MATCH_EA;
				end
			end
			default: begin
				if (fresh_pend) begin
					match_d = pce_pkg::MATCH_EA;
				end
			end
		endcase
	end

	// Entry contents for the current item.
	always_comb begin
		push_entry.body  = in_byte;
		push_entry.fin   = final_byte;
		push_entry.pfx_n = 2'd0;
		push_entry.kind  = fresh_kind;
		case (match_q)
			pce_pkg::MATCH_EA: begin
				if (in_byte == pce_pkg::PFX_SECOND && !final_byte) begin
					push_entry.kind = pce_pkg::BODY_NONE;
				end else begin
					push_entry.pfx_n = 2'd1;
				end
			end
			pce_pkg::MATCH_EA9E: begin
				if (in_byte == pce_pkg::PFX_THIRD) begin
					push_entry.kind = pce_pkg::BODY_ESC;
					push_entry.body = pce_pkg::CHAR_COLON;
				end else begin
					push_entry.pfx_n = 2'd2;
				end
			end
			default: ;
		endcase
		emits = (push_entry.pfx_n != 2'd0) || (push_entry.kind != pce_pkg::BODY_NONE);
		push  = accept && emits;
	end

	// Match state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= pce_pkg::MATCH_IDLE;
		end else if (accept) begin
			match_q <= match_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/pce_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pce_queue: entry queue between front and back
// A small first-in first-out buffer of classified entries; DEPTH must be a
// power of two, at least two, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module pce_queue #(
	parameter int DEPTH = pce_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pce_pkg::entry_t push_entry,
	input  wire logic            pop,
	output logic                 full,
	output logic                 empty,
	output pce_pkg::entry_t      head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pce_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/pce_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pce_back: output side of the escaper
// Walks the head entry one output byte per cycle, unless the output stalls,
// into an output register and retires the entry with its last byte.
// ---------------------------------------------------------------------------
module pce_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	input  wire pce_pkg::entry_t head,
	output logic                 pop,
	output logic                 dst_valid,
	input  wire logic            dst_stall,
	output logic [7:0]           out_byte,
	output logic                 run_end,
	output logic                 string_end
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic [2:0] rel;
	logic       last;
	logic       load;
	logic [7:0] sel_byte;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       string_end_q;

	// Output register is free when empty or being taken this cycle.
	assign load = !q_empty && (!valid_q || !dst_stall);

	// Number of bytes the head entry produces, and position within it.
	always_comb begin
		total = {1'b0, head.pfx_n};
		case (head.kind)
			pce_pkg::BODY_LIT: total = {1'b0, head.pfx_n} + 3'd1;
			pce_pkg::BODY_ESC: total = {1'b0, head.pfx_n} + 3'd3;
			default: ;
		endcase
		rel  = idx_q - {1'b0, head.pfx_n};
		last = (idx_q == total - 3'd1);
		pop  = load && last;
	end

	// Byte at the current position.
	always_comb begin
		if (idx_q < {1'b0, head.pfx_n}) begin
			sel_byte = (idx_q == 3'd0) ? pce_pkg::PFX_FIRST : pce_pkg::PFX_SECOND;
		end else if (head.kind == pce_pkg::BODY_ESC) begin
			case (rel)
				3'd0:    sel_byte = pce_pkg::CHAR_PCT;
				3'd1:    sel_byte = pce_pkg::hex_digit(head.body[7:4]);
				default: sel_byte = pce_pkg::hex_digit(head.body[3:0]);
			endcase
		end else begin
			sel_byte = head.body;
		end
	end

	// Position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (!dst_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= sel_byte;
			run_end_q    <= last;
			string_end_q <= last && head.fin;
		end
	end

	assign dst_valid  = valid_q;
	assign out_byte   = byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

endmodule
`default_nettype wire
